FILE: hdl/elst_pkg.sv
// Shared constants, codes and types of the extent list scatter translator.
package elst_pkg;

	localparam int MAX_EXTENT_ENTRIES = 32;
	localparam int CNT_W = $clog2(MAX_EXTENT_ENTRIES + 1);
	localparam int IDX_W = (MAX_EXTENT_ENTRIES > 1) ? $clog2(MAX_EXTENT_ENTRIES) : 1;

	localparam int SPAN_W = 48;
	localparam int LG_W = SPAN_W + CNT_W;
	localparam int ADDR_W = 50;
	localparam int SECTOR_SHIFT = 9;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_ALLOC_BLOCK_BYTES = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ALLOC_AREA_START = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FORK_SIZE_BYTES = 2'd2;

	localparam logic [31:0] ALLOC_BLOCK_BYTES_RST = 32'd512;
	localparam logic [15:0] ALLOC_AREA_START_RST = 16'd0;
	localparam logic [31:0] FORK_SIZE_BYTES_RST = 32'd0;

	localparam logic [1:0] CMD_CLEAR = 2'd0;
	localparam logic [1:0] CMD_APPEND = 2'd1;
	localparam logic [1:0] CMD_XLATE = 2'd2;

	localparam logic [2:0] ST_PIECE = 3'd0;
	localparam logic [2:0] ST_RANGE = 3'd1;
	localparam logic [2:0] ST_SHORT = 3'd2;
	localparam logic [2:0] ST_DONE = 3'd3;
	localparam logic [2:0] ST_APPENDED = 3'd4;
	localparam logic [2:0] ST_FULL = 3'd5;
	localparam logic [2:0] ST_CLEARED = 3'd6;

	typedef enum logic [2:0] {
		K_CLEAR,
		K_APPEND,
		K_APPEND_NOP,
		K_REJECT,
		K_EMPTY,
		K_XLATE
	} kind_t;

	typedef struct packed {
		kind_t kind;
		logic [31:0] offset;
		logic [31:0] req_end;
		logic [15:0] first_block;
		logic [15:0] block_total;
	} desc_t;

endpackage

FILE: hdl/elst_in_if.sv
// Command channel: valid/ready handshake with the command payload.
interface elst_in_if;
	logic valid;
	logic ready;
	logic [1:0] cmd;
	logic [31:0] logical_offset;
	logic [31:0] request_length;
	logic [15:0] extent_first_block;
	logic [15:0] extent_block_total;

	modport source (
		output valid, cmd, logical_offset, request_length, extent_first_block,
			extent_block_total,
		input ready
	);
	modport sink (
		input valid, cmd, logical_offset, request_length, extent_first_block,
			extent_block_total,
		output ready
	);
endinterface

FILE: hdl/elst_out_if.sv
// Result channel: valid/ready handshake with the result payload.
interface elst_out_if;
	logic valid;
	logic ready;
	logic [2:0] status;
	logic [49:0] physical_address;
	logic [31:0] piece_length;
	logic last;

	modport source (
		output valid, status, physical_address, piece_length, last,
		input ready
	);
	modport sink (
		input valid, status, physical_address, piece_length, last,
		output ready
	);
endinterface

FILE: hdl/elst_front.sv
// Front end: takes command beats, range-checks translates and builds descriptors.
module elst_front import elst_pkg::*; (
	elst_in_if.sink req,
	input logic [31:0] fork_size_bytes,
	input logic q_full,
	output logic q_push,
	output desc_t q_desc
);

	logic [31:0] headroom;
	logic over;

	assign req.ready = !q_full;
	// unused command code is taken and dropped
	assign q_push = req.valid && !q_full &&
		(req.cmd == CMD_CLEAR || req.cmd == CMD_APPEND || req.cmd == CMD_XLATE);

	assign headroom = fork_size_bytes - req.logical_offset;
	assign over = (req.logical_offset > fork_size_bytes) || (req.request_length > headroom);

	always_comb begin
		q_desc.offset = req.logical_offset;
		q_desc.req_end = req.logical_offset + req.request_length;
		q_desc.first_block = req.extent_first_block;
		q_desc.block_total = req.extent_block_total;
		unique case (req.cmd)
			CMD_CLEAR: q_desc.kind = K_CLEAR;
			CMD_APPEND: q_desc.kind = (req.extent_block_total == 16'd0) ? K_APPEND_NOP : K_APPEND;
			CMD_XLATE: begin
				if (over)
					q_desc.kind = K_REJECT;
				else if (req.request_length == 32'd0)
					q_desc.kind = K_EMPTY;
				else
					q_desc.kind = K_XLATE;
			end
			default: q_desc.kind = K_CLEAR;
		endcase
	end

endmodule

FILE: hdl/elst_queue.sv
// Descriptor queue between front end and walk engine.
module elst_queue import elst_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic push,
	input desc_t push_desc,
	output logic full,
	input logic pop,
	output desc_t pop_desc,
	output logic empty
);

	desc_t slots [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] fill_q;

	assign full = (fill_q == QCNT_W'(QUEUE_DEPTH));
	assign empty = (fill_q == '0);
	assign pop_desc = slots[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			slots[wr_ptr_q] <= push_desc;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)
				fill_q <= fill_q + 1'b1;
			else if (pop && !push)
				fill_q <= fill_q - 1'b1;
		end
	end

endmodule

FILE: hdl/elst_back.sv
// Walk engine: extent table, table walk pipeline and result register.
module elst_back import elst_pkg::*; (
	input logic clk,
	input logic arst_n,
	input desc_t q_desc,
	input logic q_empty,
	output logic q_pop,
	input logic [31:0] alloc_block_bytes,
	input logic [15:0] alloc_area_start,
	elst_out_if.source rsp
);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_WALK = 3'b010,
		S_CLOSE = 3'b100
	} state_t;

	state_t state_q;
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] rd_q;
	logic [31:0] table_mem [MAX_EXTENT_ENTRIES];

	logic [31:0] ent_s1;
	logic v_s1;
	logic [SPAN_W-1:0] span_s2;
	logic [SPAN_W-1:0] fpart_s2;
	logic v_s2;
	logic [LG_W-1:0] lg_q;
	logic [LG_W-1:0] end_s3;
	logic [LG_W-1:0] lg_s3;
	logic [ADDR_W-1:0] bml_s3;
	logic v_s3;

	logic [31:0] offset_q;
	logic [31:0] req_end_q;
	logic [31:0] pos_q;

	logic out_vld_q;
	logic [2:0] status_q;
	logic [ADDR_W-1:0] addr_q;
	logic [31:0] len_q;
	logic last_q;

	logic adv;
	logic issue;
	logic exhausted;
	logic table_full;
	logic skip;
	logic piece;
	logic fit;
	logic [31:0] take;
	logic [31:0] pos_nx;

	logic emit;
	logic [2:0] emit_status;
	logic [ADDR_W-1:0] emit_addr;
	logic [31:0] emit_len;
	logic emit_last;

	assign adv = !out_vld_q || rsp.ready;
	assign q_pop = (state_q == S_IDLE) && !q_empty && adv;
	assign issue = (state_q == S_WALK) && adv && (rd_q != cnt_q);
	assign exhausted = (state_q == S_WALK) && (rd_q == cnt_q) && !v_s1 && !v_s2 && !v_s3;
	assign table_full = (cnt_q == CNT_W'(MAX_EXTENT_ENTRIES));

	// Once a piece has been taken, pos sits on the start of the next extent,
	// so pos never passes end here and end - pos is the bytes left in it.
	assign skip = (LG_W'(offset_q) >= end_s3) || (LG_W'(pos_q) < lg_s3);
	assign piece = !skip && (end_s3 != LG_W'(pos_q));
	assign fit = (LG_W'(req_end_q) <= end_s3);
	assign take = fit ? (req_end_q - pos_q) : (end_s3[31:0] - pos_q);
	assign pos_nx = fit ? req_end_q : end_s3[31:0];

	always_comb begin
		emit = 1'b0;
		emit_status = ST_PIECE;
		emit_addr = '0;
		emit_len = '0;
		emit_last = 1'b1;
		unique case (state_q)
			S_IDLE: begin
				if (!q_empty) begin
					emit = 1'b1;
					case (q_desc.kind)
						K_CLEAR: emit_status = ST_CLEARED;
						K_APPEND: emit_status = table_full ? ST_FULL : ST_APPENDED;
						K_APPEND_NOP: emit_status = ST_APPENDED;
						K_REJECT: emit_status = ST_RANGE;
						K_EMPTY: emit_status = ST_DONE;
						default: emit = 1'b0;
					endcase
				end
			end
			S_WALK: begin
				emit = v_s3 && piece;
				emit_status = ST_PIECE;
				emit_addr = bml_s3 + ADDR_W'(pos_q);
				emit_len = take;
				emit_last = 1'b0;
			end
			S_CLOSE: begin
				emit = 1'b1;
				emit_status = (pos_q == req_end_q) ? ST_DONE : ST_SHORT;
			end
			default: emit = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (q_pop && q_desc.kind == K_APPEND && !table_full)
			table_mem[cnt_q[IDX_W-1:0]] <= {q_desc.first_block, q_desc.block_total};
		if (issue)
			ent_s1 <= table_mem[rd_q[IDX_W-1:0]];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			span_s2 <= SPAN_W'(ent_s1[15:0]) * SPAN_W'(alloc_block_bytes);
			fpart_s2 <= SPAN_W'(ent_s1[31:16]) * SPAN_W'(alloc_block_bytes);
			end_s3 <= lg_q + LG_W'(span_s2);
			lg_s3 <= lg_q;
			// area base plus extent base, minus the extent's logical start
			bml_s3 <= ADDR_W'({alloc_area_start, {SECTOR_SHIFT{1'b0}}}) + ADDR_W'(fpart_s2)
				- ADDR_W'(lg_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q <= '0;
			rd_q <= '0;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			lg_q <= '0;
			offset_q <= '0;
			req_end_q <= '0;
			pos_q <= '0;
		end else if (adv) begin
			unique case (state_q)
				S_IDLE: begin
					if (!q_empty) begin
						case (q_desc.kind)
							K_CLEAR: cnt_q <= '0;
							K_APPEND: begin
								if (!table_full)
									cnt_q <= cnt_q + 1'b1;
							end
							K_XLATE: begin
								state_q <= S_WALK;
								rd_q <= '0;
								lg_q <= '0;
								v_s1 <= 1'b0;
								v_s2 <= 1'b0;
								v_s3 <= 1'b0;
								offset_q <= q_desc.offset;
								req_end_q <= q_desc.req_end;
								pos_q <= q_desc.offset;
							end
							default: state_q <= S_IDLE;
						endcase
					end
				end
				S_WALK: begin
					if (issue)
						rd_q <= rd_q + 1'b1;
					if (v_s2)
						lg_q <= lg_q + LG_W'(span_s2);
					if (v_s3 && piece)
						pos_q <= pos_nx;
					if (v_s3 && piece && fit) begin
						state_q <= S_CLOSE;
						v_s1 <= 1'b0;
						v_s2 <= 1'b0;
						v_s3 <= 1'b0;
					end else begin
						v_s1 <= issue;
						v_s2 <= v_s1;
						v_s3 <= v_s2;
						if (exhausted)
							state_q <= S_CLOSE;
					end
				end
				S_CLOSE: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_vld_q <= 1'b0;
		else if (adv)
			out_vld_q <= emit;
	end

	always_ff @(posedge clk) begin
		if (adv && emit) begin
			status_q <= emit_status;
			addr_q <= emit_addr;
			len_q <= emit_len;
			last_q <= emit_last;
		end
	end

	assign rsp.valid = out_vld_q;
	assign rsp.status = status_q;
	assign rsp.physical_address = addr_q;
	assign rsp.piece_length = len_q;
	assign rsp.last = last_q;

endmodule

FILE: hdl/extent_list_scatter_translator_unit.sv
// Extent list scatter translator top level: config registers, front end, queue, walk engine.
// Commands are queued, popped by the walk engine while idle and registered as result beats;
// a translate walks the table one entry per cycle while the result channel is not stalled and
// holds the engine until its closing beat, once covered or out of entries. One table read port,
// three-stage lead-in. Throughput: one single-beat command per cycle while idle and not stalled.
// Reset clears the entry count, queue and result valid, config to defaults; table not cleared.
module extent_list_scatter_translator_unit import elst_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic cfg_wr_en,
	input logic [CFG_IDX_W-1:0] cfg_index,
	input logic [31:0] cfg_wdata,
	elst_in_if.sink req,
	elst_out_if.source rsp
);

	logic [31:0] alloc_block_bytes_q;
	logic [15:0] alloc_area_start_q;
	logic [31:0] fork_size_bytes_q;

	logic q_full;
	logic q_empty;
	logic q_push;
	logic q_pop;
	desc_t push_desc;
	desc_t pop_desc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alloc_block_bytes_q <= ALLOC_BLOCK_BYTES_RST;
			alloc_area_start_q <= ALLOC_AREA_START_RST;
			fork_size_bytes_q <= FORK_SIZE_BYTES_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_ALLOC_BLOCK_BYTES: alloc_block_bytes_q <= cfg_wdata;
				REG_ALLOC_AREA_START: alloc_area_start_q <= cfg_wdata[15:0];
				REG_FORK_SIZE_BYTES: fork_size_bytes_q <= cfg_wdata;
				default: alloc_block_bytes_q <= alloc_block_bytes_q;
			endcase
		end
	end

	elst_front u_front (
		.req(req),
		.fork_size_bytes(fork_size_bytes_q),
		.q_full(q_full),
		.q_push(q_push),
		.q_desc(push_desc)
	);

	elst_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(q_push),
		.push_desc(push_desc),
		.full(q_full),
		.pop(q_pop),
		.pop_desc(pop_desc),
		.empty(q_empty)
	);

	elst_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q_desc(pop_desc),
		.q_empty(q_empty),
		.q_pop(q_pop),
		.alloc_block_bytes(alloc_block_bytes_q),
		.alloc_area_start(alloc_area_start_q),
		.rsp(rsp)
	);

endmodule

FILE: hdl/elst_checker.sv
// Port-level checks on the result channel, bound to the top level.
module elst_checker import elst_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic rsp_valid,
	input logic rsp_ready,
	input logic [2:0] rsp_status,
	input logic [49:0] rsp_physical_address,
	input logic [31:0] rsp_piece_length,
	input logic rsp_last
);

	// stalled result beat holds
	ap_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
			$stable(rsp_physical_address) && $stable(rsp_piece_length) && $stable(rsp_last))
		else $error("result beat changed while stalled");

	// only pieces are non-final
	ap_last_vs_piece: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> ((rsp_status == ST_PIECE) != rsp_last))
		else $error("last flag does not match piece status");

	ap_final_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_last |-> (rsp_physical_address == '0) && (rsp_piece_length == '0))
		else $error("final beat carries address or length");

	ap_piece_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_status == ST_PIECE) |-> (rsp_piece_length != '0))
		else $error("empty piece emitted");

endmodule

bind extent_list_scatter_translator_unit elst_checker u_elst_checker (
	.clk(clk),
	.arst_n(arst_n),
	.rsp_valid(rsp.valid),
	.rsp_ready(rsp.ready),
	.rsp_status(rsp.status),
	.rsp_physical_address(rsp.physical_address),
	.rsp_piece_length(rsp.piece_length),
	.rsp_last(rsp.last)
);

FILE: tb/extent_list_scatter_translator_unit_tb.sv
// Testbench for the extent list scatter translator: directed table, random sequences, predictor.
`timescale 1ns / 1ps

module extent_list_scatter_translator_unit_tb;
	import elst_pkg::*;

	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam logic [63:0] SECTOR_BYTES = 64'd512;
	localparam int LATENCY_PAD = 48;
	localparam int ITEM_TARGET = 260;
	localparam int PRINT_LIMIT = 40;
	localparam int N_DIRECTED = 28;

	typedef struct packed {
		logic [1:0] cmd;
		logic [31:0] offset;
		logic [31:0] length;
		logic [15:0] first;
		logic [15:0] total;
	} command_t;

	typedef struct packed {
		logic [2:0] status;
		logic [49:0] addr;
		logic [31:0] len;
		logic last;
	} xlate_result_t;

	typedef enum logic {
		ROW_BEAT,
		ROW_REG
	} row_kind_t;

	typedef struct packed {
		row_kind_t kind;
		logic [CFG_IDX_W-1:0] reg_idx;
		logic [31:0] reg_val;
		command_t beat;
		logic pinned;
		logic [2:0] pinned_status;
	} directed_row_t;

	logic clk;
	logic arst_n;
	logic cfg_wr_en;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [31:0] cfg_wdata;

	elst_in_if req ();
	elst_out_if rsp ();

	extent_list_scatter_translator_unit i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.req(req),
		.rsp(rsp)
	);

	// shadow of the block state
	logic [15:0] ext_first [MAX_EXTENT_ENTRIES];
	logic [15:0] ext_count [MAX_EXTENT_ENTRIES];
	int unsigned n_extents;
	logic [31:0] blk_bytes;
	logic [15:0] area_start;
	logic [31:0] fork_bytes;

	xlate_result_t pending_results [$];
	int unsigned mismatches = 0;
	int unsigned items_sent = 0;
	int unsigned send_gap_max = 10;
	int unsigned recv_stall_max = 10;

	directed_row_t directed_rows [N_DIRECTED] = '{
		'{ROW_BEAT, '0, '0, '{CMD_XLATE, 32'd0, 32'd0, 16'd0, 16'd0}, 1'b1, ST_DONE},
		'{ROW_BEAT, '0, '0, '{CMD_XLATE, 32'd1, 32'd0, 16'd0, 16'd0}, 1'b1, ST_RANGE},
		'{ROW_BEAT, '0, '0, '{CMD_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF},
			1'b0, '0},
		'{ROW_BEAT, '0, '0, '{CMD_APPEND, 32'd0, 32'd0, 16'd0, 16'd0}, 1'b1, ST_APPENDED},
		'{ROW_BEAT, '0, '0, '{CMD_XLATE, 32'd0, 32'd1, 16'd0, 16'd0}, 1'b1, ST_RANGE},
		'{ROW_REG, REG_FORK_SIZE_BYTES, 32'hFFFF_FFFF, '0, 1'b0, '0},
		'{ROW_REG, REG_ALLOC_AREA_START, 32'h0000_FFFF, '0, 1'b0, '0},
		'{ROW_REG, REG_ALLOC_BLOCK_BYTES, 32'd512, '0, 1'b0, '0},
		'{ROW_BEAT, '0, '0, '{CMD_XLATE, 32'd0, 32'd1, 16'd0, 16'd0}, 1'b1, ST_SHORT},
		'{ROW_BEAT, '0, '0, '{CMD_APPEND, 32'd0, 32'd0, 16'hFFFF, 16'hFFFF}, 1'b1, ST_APPENDED},
		'{ROW_BEAT, '0, '0, '{CMD_APPEND, 32'd0, 32'd0, 16'd0, 16'd1}, 1'b1, ST_APPENDED},
		'{ROW_BEAT, '0, '0, '{CMD_XLATE, 32'd0, 32'hFFFF_FFFF, 16'd0, 16'd0}, 1'b0, '0},
		'{ROW_BEAT, '0, '0, '{CMD_XLATE, 32'd100, 32'd33553900, 16'd0, 16'd0}, 1'b0, '0},
		'{ROW_BEAT, '0, '0, '{CMD_XLATE, 32'd33553920, 32'd512, 16'd0, 16'd0}, 1'b0, '0},
		'{ROW_BEAT, '0, '0, '{CMD_XLATE, 32'hFFFF_FFFF, 32'd0, 16'd0, 16'd0}, 1'b1, ST_DONE},
		'{ROW_BEAT, '0, '0, '{CMD_XLATE, 32'hFFFF_FFFF, 32'd1, 16'd0, 16'd0}, 1'b1, ST_RANGE},
		'{ROW_REG, REG_ALLOC_BLOCK_BYTES, 32'hFFFF_FFFF, '0, 1'b0, '0},
		'{ROW_BEAT, '0, '0, '{CMD_XLATE, 32'hFFFF_0000, 32'h0000_FFFF, 16'd0, 16'd0}, 1'b0, '0},
		'{ROW_REG, REG_ALLOC_BLOCK_BYTES, 32'd0, '0, 1'b0, '0},
		'{ROW_BEAT, '0, '0, '{CMD_APPEND, 32'd0, 32'd0, 16'h1234, 16'd10}, 1'b1, ST_APPENDED},
		'{ROW_BEAT, '0, '0, '{CMD_XLATE, 32'd0, 32'd5, 16'd0, 16'd0}, 1'b1, ST_SHORT},
		'{ROW_BEAT, '0, '0, '{CMD_XLATE, 32'd0, 32'd0, 16'd0, 16'd0}, 1'b1, ST_DONE},
		'{ROW_REG, REG_ALLOC_BLOCK_BYTES, 32'd513, '0, 1'b0, '0},
		'{ROW_REG, REG_ALLOC_AREA_START, 32'd0, '0, 1'b0, '0},
		'{ROW_BEAT, '0, '0, '{CMD_XLATE, 32'd7, 32'd40000, 16'd0, 16'd0}, 1'b0, '0},
		'{ROW_BEAT, '0, '0, '{CMD_CLEAR, 32'd0, 32'd0, 16'd0, 16'd0}, 1'b1, ST_CLEARED},
		'{ROW_BEAT, '0, '0, '{CMD_XLATE, 32'd0, 32'd0, 16'd0, 16'd0}, 1'b1, ST_DONE},
		'{ROW_BEAT, '0, '0, '{CMD_APPEND, 32'd0, 32'd0, 16'h8000, 16'h8000}, 1'b1, ST_APPENDED}
	};

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	task automatic report_mismatch(input string msg);
		mismatches++;
		if (mismatches <= PRINT_LIMIT)
			$display("[%0t] MISMATCH: %s", $time, msg);
	endtask

	function automatic void push_result(input logic [2:0] status, input logic [63:0] addr,
			input logic [63:0] len, input logic last);
		xlate_result_t r;
		r.status = status;
		r.addr = addr[49:0];
		r.len = len[31:0];
		r.last = last;
		pending_results.push_back(r);
	endfunction

	// Updates the shadow state and queues the beats the command must produce.
	function automatic void apply_command(input command_t c);
		logic [63:0] span, ext_end, pos, ext_off, avail, take, done, logical, addr;
		int unsigned idx;
		case (c.cmd)
			CMD_CLEAR: begin
				n_extents = 0;
				push_result(ST_CLEARED, 0, 0, 1'b1);
			end
			CMD_APPEND: begin
				if (c.total == 16'd0) begin
					push_result(ST_APPENDED, 0, 0, 1'b1);
				end else if (n_extents >= MAX_EXTENT_ENTRIES) begin
					push_result(ST_FULL, 0, 0, 1'b1);
				end else begin
					ext_first[n_extents] = c.first;
					ext_count[n_extents] = c.total;
					n_extents++;
					push_result(ST_APPENDED, 0, 0, 1'b1);
				end
			end
			CMD_XLATE: begin
				if (c.offset > fork_bytes || c.length > fork_bytes - c.offset) begin
					push_result(ST_RANGE, 0, 0, 1'b1);
				end else begin
					done = 0;
					logical = 0;
					for (idx = 0; idx < n_extents && done < c.length; idx++) begin
						span = ext_count[idx] * blk_bytes;
						ext_end = logical + span;
						pos = c.offset + done;
						if (!(c.offset >= ext_end || pos < logical)) begin
							ext_off = pos - logical;
							avail = span - ext_off;
							take = c.length - done;
							if (take > avail)
								take = avail;
							// zero block size gives extents with no bytes: no piece
							if (take != 0) begin
								addr = area_start * SECTOR_BYTES + ext_first[idx] * blk_bytes
									+ ext_off;
								push_result(ST_PIECE, addr, take, 1'b0);
								done += take;
							end
						end
						logical = ext_end;
					end
					push_result((done == c.length) ? ST_DONE : ST_SHORT, 0, 0, 1'b1);
				end
			end
			default: ;
		endcase
	endfunction

	function automatic logic [31:0] rand_upto(input logic [31:0] hi);
		rand_upto = (hi == 32'hFFFF_FFFF) ? $urandom : $urandom % (hi + 32'd1);
	endfunction

	function automatic command_t make_append();
		command_t c;
		c.cmd = CMD_APPEND;
		c.offset = $urandom;
		c.length = $urandom;
		c.first = 16'($urandom);
		c.total = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(1, 65535)) :
			16'($urandom_range(1, 16));
		return c;
	endfunction

	function automatic command_t make_translate();
		command_t c;
		logic [63:0] mapped, lim;
		int unsigned idx, pick;
		mapped = 0;
		for (idx = 0; idx < n_extents; idx++)
			mapped += ext_count[idx] * blk_bytes;
		lim = (mapped > fork_bytes) ? fork_bytes : mapped;
		c.cmd = CMD_XLATE;
		c.first = 16'($urandom);
		c.total = 16'($urandom);
		pick = $urandom_range(0, 9);
		if (pick == 0) begin
			c.offset = $urandom;
			c.length = $urandom;
		end else if (pick == 1) begin
			// start right at the end of the mapped range
			c.offset = lim[31:0];
			c.length = $urandom_range(0, 1) ? 32'd0 : $urandom_range(1, 4096);
		end else begin
			c.offset = rand_upto(lim[31:0]);
			c.length = rand_upto(lim[31:0] - c.offset);
			if (pick <= 4)
				c.length = c.length & 32'h0000_0FFF;
		end
		return c;
	endfunction

	function automatic command_t make_noise();
		command_t c;
		c.offset = $urandom;
		c.length = $urandom;
		c.first = 16'($urandom);
		c.total = 16'($urandom);
		case ($urandom_range(0, 2))
			0: c.cmd = CMD_UNUSED;
			1: begin
				c.cmd = CMD_APPEND;
				c.total = 16'd0;
			end
			default: c.cmd = CMD_XLATE;
		endcase
		return c;
	endfunction

	// Called at a rising edge; returns at the edge where the beat is taken.
	task automatic send_command(input command_t c, input logic pinned,
			input logic [2:0] pinned_status);
		int unsigned gap;
		int unsigned n0;
		gap = $urandom_range(0, send_gap_max);
		if (gap > 0) begin
			req.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req.valid <= 1'b1;
		req.cmd <= c.cmd;
		req.logical_offset <= c.offset;
		req.request_length <= c.length;
		req.extent_first_block <= c.first;
		req.extent_block_total <= c.total;
		do @(posedge clk); while (req.ready !== 1'b1);
		n0 = pending_results.size();
		apply_command(c);
		if (pinned) begin
			while (pending_results.size() > n0)
				void'(pending_results.pop_back());
			push_result(pinned_status, 0, 0, 1'b1);
		end
		if (c.cmd != CMD_UNUSED)
			items_sent++;
	endtask

	task automatic drain_results();
		req.valid <= 1'b0;
		do @(posedge clk); while (pending_results.size() != 0);
	endtask

	// idle point for register writes: no result pending and no walk in flight
	task automatic settle();
		drain_results();
		repeat (LATENCY_PAD) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		@(posedge clk);
		case (idx)
			REG_ALLOC_BLOCK_BYTES: blk_bytes = val;
			REG_ALLOC_AREA_START: area_start = val[15:0];
			REG_FORK_SIZE_BYTES: fork_bytes = val;
			default: ;
		endcase
	endtask

	task automatic random_config();
		logic [31:0] bsz, fsz;
		logic [15:0] start;
		case ($urandom_range(0, 9))
			0: bsz = 32'd512;
			1: bsz = 32'd0;
			2: bsz = 32'd1;
			3: bsz = 32'hFFFF_FFFF;
			4: bsz = 32'hFFFF_FE00;
			5: bsz = $urandom;
			default: bsz = 32'd512 * $urandom_range(1, 16);
		endcase
		case ($urandom_range(0, 3))
			0: start = 16'd0;
			1: start = 16'hFFFF;
			default: start = 16'($urandom);
		endcase
		case ($urandom_range(0, 9))
			0: fsz = 32'd0;
			1: fsz = $urandom_range(0, 100000);
			2, 3: fsz = $urandom;
			default: fsz = 32'hFFFF_FFFF;
		endcase
		write_reg(REG_ALLOC_BLOCK_BYTES, bsz);
		write_reg(REG_ALLOC_AREA_START, {16'd0, start});
		write_reg(REG_FORK_SIZE_BYTES, fsz);
	endtask

	// clear (not on every sequence), build a table, then translate against it; noise sprinkled in
	task automatic run_sequence(input bit fill_table);
		command_t c;
		int unsigned n_appends, n_xlates, j;
		if (fill_table || $urandom_range(0, 5) != 0) begin
			c = make_noise();
			c.cmd = CMD_CLEAR;
			send_command(c, 1'b0, ST_PIECE);
		end
		if (fill_table)
			n_appends = MAX_EXTENT_ENTRIES + 2;
		else if ($urandom_range(0, 4) == 0)
			n_appends = $urandom_range(28, 36);
		else
			n_appends = $urandom_range(1, 8);
		for (j = 0; j < n_appends; j++) begin
			if ($urandom_range(0, 11) == 0)
				send_command(make_noise(), 1'b0, ST_PIECE);
			send_command(make_append(), 1'b0, ST_PIECE);
		end
		n_xlates = $urandom_range(2, 8);
		for (j = 0; j < n_xlates; j++) begin
			if ($urandom_range(0, 15) == 0)
				drain_results();
			if ($urandom_range(0, 11) == 0)
				send_command(make_noise(), 1'b0, ST_PIECE);
			send_command(make_translate(), 1'b0, ST_PIECE);
		end
	endtask

	initial begin
		int unsigned k;
		int unsigned phase_no;
		arst_n = 1'b0;
		cfg_wr_en <= 1'b0;
		cfg_index <= REG_ALLOC_BLOCK_BYTES;
		cfg_wdata <= 32'd0;
		req.valid <= 1'b0;
		req.cmd <= CMD_CLEAR;
		req.logical_offset <= 32'd0;
		req.request_length <= 32'd0;
		req.extent_first_block <= 16'd0;
		req.extent_block_total <= 16'd0;
		n_extents = 0;
		blk_bytes = ALLOC_BLOCK_BYTES_RST;
		area_start = ALLOC_AREA_START_RST;
		fork_bytes = FORK_SIZE_BYTES_RST;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (k = 0; k < N_DIRECTED; k++) begin
			if (directed_rows[k].kind == ROW_REG) begin
				settle();
				write_reg(directed_rows[k].reg_idx, directed_rows[k].reg_val);
			end else begin
				send_command(directed_rows[k].beat, directed_rows[k].pinned,
					directed_rows[k].pinned_status);
			end
		end

		phase_no = 0;
		while (items_sent < ITEM_TARGET) begin
			settle();
			random_config();
			send_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 10;
			recv_stall_max = ($urandom_range(0, 3) == 0) ? 0 : 10;
			run_sequence(phase_no == 0);
			phase_no++;
		end

		drain_results();
		repeat (LATENCY_PAD) @(posedge clk);
		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	// result side back-pressure
	initial begin
		int unsigned stall;
		rsp.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = $urandom_range(0, recv_stall_max);
			if (stall > 0) begin
				rsp.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp.ready <= 1'b1;
			do @(posedge clk); while (rsp.valid !== 1'b1);
		end
	end

	always @(posedge clk) begin
		xlate_result_t got, want;
		if (arst_n === 1'b1 && rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
			got.status = rsp.status;
			got.addr = rsp.physical_address;
			got.len = rsp.piece_length;
			got.last = rsp.last;
			if (pending_results.size() == 0) begin
				report_mismatch($sformatf("result beat with nothing pending: st=%0d addr=%h len=%h",
					got.status, got.addr, got.len));
			end else begin
				want = pending_results.pop_front();
				if (got.status !== want.status || got.addr !== want.addr ||
						got.len !== want.len || got.last !== want.last)
					report_mismatch($sformatf(
						"got st=%0d addr=%h len=%h last=%b, want st=%0d addr=%h len=%h last=%b",
						got.status, got.addr, got.len, got.last,
						want.status, want.addr, want.len, want.last));
			end
		end
	end

	initial begin
		#20ms;
		$display("end of test: mismatches");
		$finish;
	end

endmodule
